// ----- hdl/tts_pkg.sv -----
package tts_pkg;

	// Input event kinds
	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_PEER    = 2'd1;
	localparam logic [1:0] MODE_TIMEOUT = 2'd2;
	localparam logic [1:0] MODE_CHUNK   = 2'd3;

	// TFTP opcodes
	localparam logic [15:0] OP_RRQ   = 16'd1;
	localparam logic [15:0] OP_WRQ   = 16'd2;
	localparam logic [15:0] OP_DATA  = 16'd3;
	localparam logic [15:0] OP_ACK   = 16'd4;
	localparam logic [15:0] OP_ERROR = 16'd5;

	// Open outcomes
	localparam logic [1:0] OPEN_OK     = 2'd0;
	localparam logic [1:0] OPEN_DENIED = 2'd1;

	// Result actions
	localparam logic [2:0] ACT_DATA  = 3'd0;
	localparam logic [2:0] ACT_ACK   = 3'd1;
	localparam logic [2:0] ACT_ERR   = 3'd2;
	localparam logic [2:0] ACT_TID   = 3'd3;
	localparam logic [2:0] ACT_FETCH = 3'd4;
	localparam logic [2:0] ACT_STORE = 3'd5;
	localparam logic [2:0] ACT_END   = 3'd6;

	// TFTP error codes
	localparam logic [2:0] ERR_UNDEF   = 3'd0;
	localparam logic [2:0] ERR_ACCESS  = 3'd2;
	localparam logic [2:0] ERR_ILLEGAL = 3'd4;
	localparam logic [2:0] ERR_TID     = 3'd5;

	// Register indexes
	localparam logic REG_BLOCK_SIZE   = 1'b0;
	localparam logic REG_MAX_ATTEMPTS = 1'b1;

	localparam logic [9:0] FULL_BLOCK  = 10'd512;
	localparam logic [9:0] HEADER_LEN  = 10'd4;
	localparam logic [9:0] BS_RESET    = 10'd512;
	localparam logic [3:0] MAXA_RESET  = 4'd5;

	// One result item
	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] out_block;
		logic [2:0]  err_code;
		logic [9:0]  out_len;
		logic        finished;
	} res_t;

	// Queue entry: one or two results of one event
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} entry_t;

	function automatic res_t mk_res(logic [2:0] act, logic [15:0] blk, logic [2:0] err,
		logic [9:0] len, logic fin);
		res_t r;
		r.action    = act;
		r.out_block = blk;
		r.err_code  = err;
		r.out_len   = len;
		r.finished  = fin;
		return r;
	endfunction

endpackage

// ----- hdl/tts_front.sv -----
module tts_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [9:0]        cfg_data,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [1:0]        mode,
	input  logic [15:0]       opcode,
	input  logic [15:0]       block_num,
	input  logic [9:0]        packet_len,
	input  logic              peer_match,
	input  logic              octet_ok,
	input  logic [1:0]        open_result,
	input  logic              read_failed,
	input  logic [9:0]        chunk_len,
	input  logic              q_full,
	output logic              q_push,
	output tts_pkg::entry_t   q_data
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_FETCH,
		PH_ACKWAIT,
		PH_DATAWAIT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] block_count_q, block_count_d;
	logic [3:0]  tries_q, tries_d;
	logic [9:0]  held_len_q, held_len_d;
	logic [9:0]  block_size_q;
	logic [3:0]  max_attempts_q;

	logic        accept;
	logic [1:0]  n_res;
	tts_pkg::res_t r0, r1, rs_res;
	logic        rs_end;
	logic [9:0]  eff_bs;
	logic [9:0]  clen_sat;
	logic [9:0]  dsz;
	logic [15:0] next_blk;
	logic        waiting;

	assign req_stall = q_full;
	assign accept    = req_valid && !q_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= tts_pkg::BS_RESET;
			max_attempts_q <= tts_pkg::MAXA_RESET;
		end else if (cfg_we) begin
			if (cfg_index == tts_pkg::REG_BLOCK_SIZE) begin
				block_size_q <= cfg_data;
			end else begin
				max_attempts_q <= cfg_data[3:0];
			end
		end
	end

	// Shared terms
	assign eff_bs   = (block_size_q > tts_pkg::FULL_BLOCK) ? tts_pkg::FULL_BLOCK : block_size_q;
	assign clen_sat = (chunk_len > eff_bs) ? eff_bs : chunk_len;
	assign next_blk = block_count_q + 16'd1;
	assign waiting  = (phase_q == PH_ACKWAIT) || (phase_q == PH_DATAWAIT);

	// DATA payload size, clamped to 0..512
	always_comb begin
		if (packet_len < tts_pkg::HEADER_LEN) begin
			dsz = 10'd0;
		end else if (packet_len - tts_pkg::HEADER_LEN > tts_pkg::FULL_BLOCK) begin
			dsz = tts_pkg::FULL_BLOCK;
		end else begin
			dsz = packet_len - tts_pkg::HEADER_LEN;
		end
	end

	// Resend of the packet in flight, or silent end
	assign rs_end = (tries_q >= max_attempts_q);
	always_comb begin
		if (rs_end) begin
			rs_res = tts_pkg::mk_res(tts_pkg::ACT_END, 16'd0, tts_pkg::ERR_UNDEF, 10'd0, 1'b1);
		end else if (phase_q == PH_ACKWAIT) begin
			rs_res = tts_pkg::mk_res(tts_pkg::ACT_DATA, block_count_q, tts_pkg::ERR_UNDEF,
				held_len_q, 1'b0);
		end else begin
			rs_res = tts_pkg::mk_res(tts_pkg::ACT_ACK, block_count_q, tts_pkg::ERR_UNDEF,
				10'd0, 1'b0);
		end
	end

	// Event classification and next state
	always_comb begin
		n_res         = 2'd0;
		r0            = '0;
		r1            = '0;
		phase_d       = phase_q;
		block_count_d = block_count_q;
		tries_d       = tries_q;
		held_len_d    = held_len_q;
		unique case (mode)
			tts_pkg::MODE_START: begin
				if (phase_q == PH_IDLE && (opcode == tts_pkg::OP_RRQ || opcode == tts_pkg::OP_WRQ))
				begin
					n_res = 2'd1;
					priority if (!octet_ok) begin
						r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_ILLEGAL,
							10'd0, 1'b1);
					end else if (open_result == tts_pkg::OPEN_DENIED) begin
						r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_ACCESS,
							10'd0, 1'b1);
					end else if (open_result != tts_pkg::OPEN_OK) begin
						r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_UNDEF,
							10'd0, 1'b1);
					end else if (opcode == tts_pkg::OP_RRQ) begin
						block_count_d = 16'd1;
						tries_d       = 4'd0;
						held_len_d    = 10'd0;
						phase_d       = PH_FETCH;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_FETCH, 16'd1, tts_pkg::ERR_UNDEF,
							10'd0, 1'b0);
					end else begin
						block_count_d = 16'd0;
						tries_d       = 4'd1;
						held_len_d    = 10'd0;
						phase_d       = PH_DATAWAIT;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_ACK, 16'd0, tts_pkg::ERR_UNDEF,
							10'd0, 1'b0);
					end
				end
			end
			tts_pkg::MODE_CHUNK: begin
				if (phase_q == PH_FETCH) begin
					n_res = 2'd1;
					if (read_failed) begin
						phase_d = PH_IDLE;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_UNDEF,
							10'd0, 1'b1);
					end else begin
						held_len_d = clen_sat;
						tries_d    = 4'd1;
						phase_d    = PH_ACKWAIT;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_DATA, block_count_q, tts_pkg::ERR_UNDEF,
							clen_sat, 1'b0);
					end
				end
			end
			tts_pkg::MODE_TIMEOUT: begin
				if (waiting) begin
					n_res = 2'd1;
					r0    = rs_res;
					if (rs_end) begin
						phase_d = PH_IDLE;
					end else begin
						tries_d = tries_q + 4'd1;
					end
				end
			end
			tts_pkg::MODE_PEER: begin
				if (waiting) begin
					priority if (!peer_match) begin
						// stranger: unknown-TID reply, then resend or silent end
						n_res = 2'd2;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_TID, 16'd0, tts_pkg::ERR_TID,
							10'd0, 1'b0);
						r1 = rs_res;
						if (rs_end) begin
							phase_d = PH_IDLE;
						end else begin
							tries_d = tries_q + 4'd1;
						end
					end else if (opcode == tts_pkg::OP_ERROR) begin
						n_res   = 2'd1;
						phase_d = PH_IDLE;
						r0 = tts_pkg::mk_res(tts_pkg::ACT_END, 16'd0, tts_pkg::ERR_UNDEF,
							10'd0, 1'b1);
					end else if (phase_q == PH_ACKWAIT) begin
						n_res = 2'd1;
						priority if (opcode != tts_pkg::OP_ACK) begin
							phase_d = PH_IDLE;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_ILLEGAL,
								10'd0, 1'b1);
						end else if (block_num != block_count_q) begin
							phase_d = PH_IDLE;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_UNDEF,
								10'd0, 1'b1);
						end else if (held_len_q < eff_bs) begin
							// short block acked: read done
							phase_d = PH_IDLE;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_END, 16'd0, tts_pkg::ERR_UNDEF,
								10'd0, 1'b1);
						end else begin
							block_count_d = next_blk;
							tries_d       = 4'd0;
							phase_d       = PH_FETCH;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_FETCH, next_blk, tts_pkg::ERR_UNDEF,
								10'd0, 1'b0);
						end
					end else begin
						priority if (opcode != tts_pkg::OP_DATA) begin
							n_res   = 2'd1;
							phase_d = PH_IDLE;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_ILLEGAL,
								10'd0, 1'b1);
						end else if (block_num != next_blk) begin
							n_res   = 2'd1;
							phase_d = PH_IDLE;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_ERR, 16'd0, tts_pkg::ERR_UNDEF,
								10'd0, 1'b1);
						end else begin
							// store payload, then ACK it; short payload ends the write
							n_res         = 2'd2;
							block_count_d = next_blk;
							r0 = tts_pkg::mk_res(tts_pkg::ACT_STORE, next_blk, tts_pkg::ERR_UNDEF,
								dsz, 1'b0);
							if (dsz < eff_bs) begin
								phase_d = PH_IDLE;
								r1 = tts_pkg::mk_res(tts_pkg::ACT_ACK, next_blk,
									tts_pkg::ERR_UNDEF, 10'd0, 1'b1);
							end else begin
								tries_d = 4'd1;
								r1 = tts_pkg::mk_res(tts_pkg::ACT_ACK, next_blk,
									tts_pkg::ERR_UNDEF, 10'd0, 1'b0);
							end
						end
					end
				end
			end
		endcase
	end

	// Transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			block_count_q <= 16'd0;
			tries_q       <= 4'd0;
			held_len_q    <= 10'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			block_count_q <= block_count_d;
			tries_q       <= tries_d;
			held_len_q    <= held_len_d;
		end
	end

	// Queue write
	assign q_push    = accept && (n_res != 2'd0);
	assign q_data.two = (n_res == 2'd2);
	assign q_data.r0  = r0;
	assign q_data.r1  = r1;

endmodule

// ----- hdl/tts_queue.sv -----
module tts_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tts_pkg::entry_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output tts_pkg::entry_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tts_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/tts_back.sv -----
module tts_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  tts_pkg::entry_t q_head,
	output logic            q_pop,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [2:0]      action,
	output logic [15:0]     out_block,
	output logic [2:0]      err_code,
	output logic [9:0]      out_len,
	output logic            finished,
	output logic            last
);

	logic          valid_q;
	logic          pend_q;
	tts_pkg::res_t out_q;
	tts_pkg::res_t pend_res_q;
	logic          last_q;
	logic          load;

	// Output register free when empty or being taken
	assign load  = !valid_q || !res_stall;
	assign q_pop = load && !pend_q && !q_empty;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				pend_q  <= q_head.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				out_q  <= pend_res_q;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				out_q      <= q_head.r0;
				last_q     <= !q_head.two;
				pend_res_q <= q_head.r1;
			end
		end
	end

	assign res_valid = valid_q;
	assign action    = out_q.action;
	assign out_block = out_q.out_block;
	assign err_code  = out_q.err_code;
	assign out_len   = out_q.out_len;
	assign finished  = out_q.finished;
	assign last      = last_q;

endmodule

// ----- hdl/tftp_transfer_sequencer_core.sv -----
// Channel   Handshake            Payload
// req       req_valid/req_stall  mode opcode block_num packet_len peer_match
//                                octet_ok open_result read_failed chunk_len
// res       res_valid/res_stall  action out_block err_code out_len finished last
// cfg       cfg_we               cfg_index cfg_data
//
// An event is classified in the cycle it is accepted; its results pass through
// the result queue and leave one per cycle through the output register while
// res_stall is low. Events with one result or none likewise sustain one per cycle;
// a two-result event holds the single-result output register for both results.
// Reset: idle phase, block size 512, five attempts, queue empty; no clearing pass.
// req_stall rises only when the event queue is full.
module tftp_transfer_sequencer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  mode,
	input  logic [15:0] opcode,
	input  logic [15:0] block_num,
	input  logic [9:0]  packet_len,
	input  logic        peer_match,
	input  logic        octet_ok,
	input  logic [1:0]  open_result,
	input  logic        read_failed,
	input  logic [9:0]  chunk_len,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  action,
	output logic [15:0] out_block,
	output logic [2:0]  err_code,
	output logic [9:0]  out_len,
	output logic        finished,
	output logic        last
);

	logic            q_full, q_push, q_pop, q_empty;
	tts_pkg::entry_t q_wdata, q_head;

	// Front end: classify events, hold transfer state
	tts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.opcode      (opcode),
		.block_num   (block_num),
		.packet_len  (packet_len),
		.peer_match  (peer_match),
		.octet_ok    (octet_ok),
		.open_result (open_result),
		.read_failed (read_failed),
		.chunk_len   (chunk_len),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// Result queue between the two halves
	tts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_head)
	);

	// Back end: serialize results onto the output channel
	tts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.action    (action),
		.out_block (out_block),
		.err_code  (err_code),
		.out_len   (out_len),
		.finished  (finished),
		.last      (last)
	);

	// A transfer-ending result closes its event
	a_fin_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!finished || last))
		else $error("finished result not marked last");

	// Unknown-TID reply always precedes a resend or end, with code 5
	a_tid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && action == tts_pkg::ACT_TID) |-> (!last && err_code == tts_pkg::ERR_TID))
		else $error("unknown-TID result malformed");

	// Second result of an event follows right after the first is taken
	a_second: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !last) |=> res_valid)
		else $error("second result not presented");

endmodule

// ----- tb/tftp_transfer_sequencer_core_test.sv -----
`timescale 1ns / 1ps

module tftp_transfer_sequencer_core_test;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 2;
	localparam int DRAIN_CYCLES = 12;
	localparam int IDLE_PCT     = 15;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_CYCLES   = 100_000;
	localparam int RANDOM_ITEMS = 200;
	localparam int REPORT_LIMIT = 10;

	// Any open outcome other than ok or denied
	localparam logic [1:0] OPEN_FAILED = 2'd2;

	typedef enum logic [1:0] {
		XFER_IDLE, XFER_FETCH, XFER_ACK_WAIT, XFER_DATA_WAIT
	} xfer_phase_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] opcode;
		logic [15:0] block_num;
		logic [9:0]  packet_len;
		logic        peer_match;
		logic        octet_ok;
		logic [1:0]  open_result;
		logic        read_failed;
		logic [9:0]  chunk_len;
	} tftp_request_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] out_block;
		logic [2:0]  err_code;
		logic [9:0]  out_len;
		logic        finished;
		logic        last;
	} tftp_action_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = tts_pkg::REG_BLOCK_SIZE;
	logic [9:0]  cfg_data = '0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  mode = tts_pkg::MODE_START;
	logic [15:0] opcode = '0;
	logic [15:0] block_num = '0;
	logic [9:0]  packet_len = '0;
	logic        peer_match = 1'b0;
	logic        octet_ok = 1'b0;
	logic [1:0]  open_result = tts_pkg::OPEN_OK;
	logic        read_failed = 1'b0;
	logic [9:0]  chunk_len = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [2:0]  action;
	logic [15:0] out_block;
	logic [2:0]  err_code;
	logic [9:0]  out_len;
	logic        finished;
	logic        last;

	tftp_transfer_sequencer_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.mode        (mode),
		.opcode      (opcode),
		.block_num   (block_num),
		.packet_len  (packet_len),
		.peer_match  (peer_match),
		.octet_ok    (octet_ok),
		.open_result (open_result),
		.read_failed (read_failed),
		.chunk_len   (chunk_len),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.action      (action),
		.out_block   (out_block),
		.err_code    (err_code),
		.out_len     (out_len),
		.finished    (finished),
		.last        (last)
	);

	always #CLK_HALF clk = ~clk;

	int  cycle_count = 0;
	logic quiet_window;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Stretch with no idling on either side
	assign quiet_window = (cycle_count >= 800) && (cycle_count < 1600);

	// Shadow of the transfer controller
	xfer_phase_t xfer_phase = XFER_IDLE;
	logic [15:0] block_count = '0;
	logic [3:0]  tries = '0;
	logic [9:0]  held_len = '0;
	logic [9:0]  cfg_block_size = tts_pkg::BS_RESET;
	logic [3:0]  cfg_max_attempts = tts_pkg::MAXA_RESET;

	tftp_request_t pending_requests [$];
	tftp_action_t  expected_actions [$];

	int requests_accepted = 0;
	int results_checked = 0;
	int failures = 0;
	int settings_used = 1;

	function automatic int eff_block_size();
		return int'((cfg_block_size > tts_pkg::FULL_BLOCK) ? tts_pkg::FULL_BLOCK
			: cfg_block_size);
	endfunction

	function automatic tftp_action_t action_of(logic [2:0] act, logic [15:0] blk,
		logic [2:0] err, logic [9:0] len, logic fin);
		tftp_action_t a;
		a.action    = act;
		a.out_block = blk;
		a.err_code  = err;
		a.out_len   = len;
		a.finished  = fin;
		a.last      = 1'b0;
		return a;
	endfunction

	function automatic tftp_action_t abort_with(logic [2:0] err);
		xfer_phase = XFER_IDLE;
		return action_of(tts_pkg::ACT_ERR, 16'd0, err, 10'd0, 1'b1);
	endfunction

	function automatic tftp_action_t end_quietly();
		xfer_phase = XFER_IDLE;
		return action_of(tts_pkg::ACT_END, 16'd0, tts_pkg::ERR_UNDEF, 10'd0, 1'b1);
	endfunction

	// Send the packet in flight again, or give up once the attempts are spent
	function automatic tftp_action_t retransmit();
		if (tries >= cfg_max_attempts)
			return end_quietly();
		tries = tries + 4'd1;
		if (xfer_phase == XFER_ACK_WAIT)
			return action_of(tts_pkg::ACT_DATA, block_count, tts_pkg::ERR_UNDEF, held_len,
				1'b0);
		return action_of(tts_pkg::ACT_ACK, block_count, tts_pkg::ERR_UNDEF, 10'd0, 1'b0);
	endfunction

	// Expected actions for one accepted request
	function automatic void predict_request(tftp_request_t q);
		tftp_action_t res [2];
		int n;
		int bs;
		logic [15:0] next_blk;
		logic [9:0] dsz;
		logic waiting;
		n = 0;
		bs = eff_block_size();
		next_blk = block_count + 16'd1;
		dsz = (q.packet_len < tts_pkg::HEADER_LEN) ? 10'd0
			: q.packet_len - tts_pkg::HEADER_LEN;
		if (dsz > tts_pkg::FULL_BLOCK)
			dsz = tts_pkg::FULL_BLOCK;
		waiting = (xfer_phase == XFER_ACK_WAIT) || (xfer_phase == XFER_DATA_WAIT);
		case (q.mode)
			tts_pkg::MODE_START: begin
				if (xfer_phase == XFER_IDLE &&
					(q.opcode == tts_pkg::OP_RRQ || q.opcode == tts_pkg::OP_WRQ)) begin
					n = 1;
					if (!q.octet_ok)
						res[0] = abort_with(tts_pkg::ERR_ILLEGAL);
					else if (q.open_result == tts_pkg::OPEN_DENIED)
						res[0] = abort_with(tts_pkg::ERR_ACCESS);
					else if (q.open_result != tts_pkg::OPEN_OK)
						res[0] = abort_with(tts_pkg::ERR_UNDEF);
					else if (q.opcode == tts_pkg::OP_RRQ) begin
						block_count = 16'd1;
						tries = 4'd0;
						held_len = 10'd0;
						xfer_phase = XFER_FETCH;
						res[0] = action_of(tts_pkg::ACT_FETCH, block_count, tts_pkg::ERR_UNDEF,
							10'd0, 1'b0);
					end else begin
						block_count = 16'd0;
						tries = 4'd1;
						held_len = 10'd0;
						xfer_phase = XFER_DATA_WAIT;
						res[0] = action_of(tts_pkg::ACT_ACK, 16'd0, tts_pkg::ERR_UNDEF, 10'd0,
							1'b0);
					end
				end
			end
			tts_pkg::MODE_CHUNK: begin
				if (xfer_phase == XFER_FETCH) begin
					n = 1;
					if (q.read_failed)
						res[0] = abort_with(tts_pkg::ERR_UNDEF);
					else begin
						held_len = (q.chunk_len > bs) ? 10'(bs) : q.chunk_len;
						tries = 4'd1;
						xfer_phase = XFER_ACK_WAIT;
						res[0] = action_of(tts_pkg::ACT_DATA, block_count, tts_pkg::ERR_UNDEF,
							held_len, 1'b0);
					end
				end
			end
			tts_pkg::MODE_TIMEOUT: begin
				if (waiting) begin
					n = 1;
					res[0] = retransmit();
				end
			end
			tts_pkg::MODE_PEER: begin
				if (!waiting) begin
					n = 0;
				end else if (!q.peer_match) begin
					n = 2;
					res[0] = action_of(tts_pkg::ACT_TID, 16'd0, tts_pkg::ERR_TID, 10'd0, 1'b0);
					res[1] = retransmit();
				end else if (q.opcode == tts_pkg::OP_ERROR) begin
					n = 1;
					res[0] = end_quietly();
				end else if (xfer_phase == XFER_ACK_WAIT) begin
					n = 1;
					if (q.opcode != tts_pkg::OP_ACK)
						res[0] = abort_with(tts_pkg::ERR_ILLEGAL);
					else if (q.block_num != block_count)
						res[0] = abort_with(tts_pkg::ERR_UNDEF);
					else if (held_len < bs)
						res[0] = end_quietly();
					else begin
						block_count = block_count + 16'd1;
						tries = 4'd0;
						xfer_phase = XFER_FETCH;
						res[0] = action_of(tts_pkg::ACT_FETCH, block_count, tts_pkg::ERR_UNDEF,
							10'd0, 1'b0);
					end
				end else begin
					n = 1;
					if (q.opcode != tts_pkg::OP_DATA)
						res[0] = abort_with(tts_pkg::ERR_ILLEGAL);
					else if (q.block_num != next_blk)
						res[0] = abort_with(tts_pkg::ERR_UNDEF);
					else begin
						n = 2;
						res[0] = action_of(tts_pkg::ACT_STORE, next_blk, tts_pkg::ERR_UNDEF, dsz,
							1'b0);
						block_count = next_blk;
						if (dsz < bs) begin
							res[1] = action_of(tts_pkg::ACT_ACK, block_count, tts_pkg::ERR_UNDEF,
								10'd0, 1'b1);
							xfer_phase = XFER_IDLE;
						end else begin
							tries = 4'd1;
							res[1] = action_of(tts_pkg::ACT_ACK, block_count, tts_pkg::ERR_UNDEF,
								10'd0, 1'b0);
						end
					end
				end
			end
		endcase
		if (n > 0)
			res[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_actions.push_back(res[i]);
	endfunction

	// Request builders: fields that do not matter stay random
	function automatic tftp_request_t random_request();
		tftp_request_t q;
		q.mode        = 2'($urandom_range(3));
		q.opcode      = $urandom_range(1) ? 16'($urandom_range(6)) : 16'($urandom);
		q.block_num   = $urandom_range(1) ? 16'($urandom_range(8)) : 16'($urandom);
		q.packet_len  = 10'($urandom_range(516));
		q.peer_match  = 1'($urandom_range(1));
		q.octet_ok    = 1'($urandom_range(1));
		q.open_result = 2'($urandom_range(2));
		q.read_failed = 1'($urandom_range(1));
		q.chunk_len   = 10'($urandom_range(512));
		return q;
	endfunction

	function automatic void push_start(logic [15:0] op, logic octet, logic [1:0] openr);
		tftp_request_t q;
		q = random_request();
		q.mode = tts_pkg::MODE_START;
		q.opcode = op;
		q.octet_ok = octet;
		q.open_result = openr;
		pending_requests.push_back(q);
	endfunction

	function automatic void push_peer(logic [15:0] op, logic [15:0] blk, logic [9:0] plen,
		logic peer);
		tftp_request_t q;
		q = random_request();
		q.mode = tts_pkg::MODE_PEER;
		q.opcode = op;
		q.block_num = blk;
		q.packet_len = plen;
		q.peer_match = peer;
		pending_requests.push_back(q);
	endfunction

	function automatic void push_timeout();
		tftp_request_t q;
		q = random_request();
		q.mode = tts_pkg::MODE_TIMEOUT;
		pending_requests.push_back(q);
	endfunction

	function automatic void push_chunk(logic rfail, logic [9:0] clen);
		tftp_request_t q;
		q = random_request();
		q.mode = tts_pkg::MODE_CHUNK;
		q.read_failed = rfail;
		q.chunk_len = clen;
		pending_requests.push_back(q);
	endfunction

	// Timeouts and stranger packets; the count may use up every attempt
	function automatic int push_retries();
		tftp_request_t q;
		int count;
		count = ($urandom_range(99) < 65) ? 0 : $urandom_range(cfg_max_attempts);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(1))
				push_timeout();
			else begin
				q = random_request();
				push_peer(q.opcode, q.block_num, q.packet_len, 1'b0);
			end
		end
		return count;
	endfunction

	// A reply from the client that ends the transfer
	function automatic void push_broken_reply(logic [15:0] blk, logic [15:0] good_op);
		case ($urandom_range(2))
			0: push_peer(tts_pkg::OP_ERROR, blk, 10'($urandom_range(516)), 1'b1);
			1: push_peer((good_op == tts_pkg::OP_ACK) ? tts_pkg::OP_DATA : tts_pkg::OP_ACK,
				blk, 10'($urandom_range(516)), 1'b1);
			default: push_peer(good_op, blk + 16'($urandom_range(65535, 1)),
				10'($urandom_range(516)), 1'b1);
		endcase
	endfunction

	// Ends any transfer left open: failed read for fetch, client error for the waits
	function automatic void queue_quiesce();
		push_chunk(1'b1, 10'($urandom_range(512)));
		push_peer(tts_pkg::OP_ERROR, 16'($urandom), 10'($urandom_range(516)), 1'b1);
	endfunction

	function automatic void queue_read_transfer(int chunks);
		logic [15:0] blk;
		int bs;
		bs = eff_block_size();
		blk = 16'd1;
		push_start(tts_pkg::OP_RRQ, 1'b1, tts_pkg::OPEN_OK);
		for (int i = 0; i < chunks; i++) begin
			if ($urandom_range(99) < 5) begin
				push_chunk(1'b1, 10'($urandom_range(512)));
				return;
			end
			if (i == chunks - 1)
				push_chunk(1'b0, 10'($urandom_range(bs - 1)));
			else
				push_chunk(1'b0, 10'($urandom_range(512, bs)));
			if (push_retries() >= cfg_max_attempts)
				return;
			if ($urandom_range(99) < 6) begin
				push_broken_reply(blk, tts_pkg::OP_ACK);
				return;
			end
			push_peer(tts_pkg::OP_ACK, blk, 10'($urandom_range(516)), 1'b1);
			blk = blk + 16'd1;
		end
	endfunction

	function automatic void queue_write_transfer(int blocks, bit noisy);
		logic [15:0] blk;
		int bs;
		int plen;
		bs = eff_block_size();
		blk = 16'd0;
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		for (int i = 0; i < blocks; i++) begin
			if (noisy && push_retries() >= cfg_max_attempts)
				return;
			blk = blk + 16'd1;
			if (noisy && $urandom_range(99) < 6) begin
				push_broken_reply(blk, tts_pkg::OP_DATA);
				return;
			end
			if (i == blocks - 1)
				plen = $urandom_range(bs + 3);
			else
				plen = $urandom_range(516, bs + 4);
			push_peer(tts_pkg::OP_DATA, blk, 10'(plen), 1'b1);
		end
	endfunction

	function automatic void queue_random(int count);
		int pick;
		while (pending_requests.size() < count) begin
			pick = $urandom_range(99);
			if (pick < 40)
				queue_read_transfer($urandom_range(4, 1));
			else if (pick < 75)
				queue_write_transfer($urandom_range(5, 1), 1'b1);
			else if (pick < 85) begin
				case ($urandom_range(2))
					0: push_start(tts_pkg::OP_RRQ, 1'($urandom_range(1)),
						2'($urandom_range(2)));
					1: push_start(tts_pkg::OP_WRQ, 1'($urandom_range(1)),
						2'($urandom_range(2)));
					default: push_start(16'($urandom), 1'($urandom_range(1)),
						2'($urandom_range(2)));
				endcase
				queue_quiesce();
			end else begin
				repeat ($urandom_range(3, 1))
					pending_requests.push_back(random_request());
				queue_quiesce();
			end
		end
	endfunction

	function automatic void queue_directed();
		// Starts that are ignored or refused
		push_start(16'hFFFF, 1'b1, tts_pkg::OPEN_OK);
		push_start(tts_pkg::OP_RRQ, 1'b0, tts_pkg::OPEN_OK);
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_DENIED);
		push_start(tts_pkg::OP_RRQ, 1'b1, OPEN_FAILED);
		// Events with no transfer running
		push_timeout();
		push_chunk(1'b0, 10'd512);
		// Read: busy start, full chunk, timeout, stranger, ack, then failed read
		push_start(tts_pkg::OP_RRQ, 1'b1, tts_pkg::OPEN_OK);
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		push_chunk(1'b0, 10'd512);
		push_timeout();
		push_peer(tts_pkg::OP_ACK, 16'd1, 10'd4, 1'b0);
		push_peer(tts_pkg::OP_ACK, 16'd1, 10'd4, 1'b1);
		push_chunk(1'b1, 10'd0);
		// Read: empty chunk acked with the wrong block
		push_start(tts_pkg::OP_RRQ, 1'b1, tts_pkg::OPEN_OK);
		push_chunk(1'b0, 10'd0);
		push_peer(tts_pkg::OP_ACK, 16'hFFFF, 10'd4, 1'b1);
		// Read: DATA where an ACK belongs
		push_start(tts_pkg::OP_RRQ, 1'b1, tts_pkg::OPEN_OK);
		push_chunk(1'b0, 10'd7);
		push_peer(tts_pkg::OP_DATA, 16'd1, 10'd516, 1'b1);
		// Write: full block, then one shorter than its header
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		push_peer(tts_pkg::OP_DATA, 16'd1, 10'd516, 1'b1);
		push_peer(tts_pkg::OP_DATA, 16'd2, 10'd2, 1'b1);
		// Write: client error, then out-of-order block
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		push_peer(tts_pkg::OP_ERROR, 16'd0, 10'd4, 1'b1);
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		push_peer(tts_pkg::OP_DATA, 16'd0, 10'd516, 1'b1);
		// Write: timeouts until the attempts run out
		push_start(tts_pkg::OP_WRQ, 1'b1, tts_pkg::OPEN_OK);
		repeat (tts_pkg::MAXA_RESET)
			push_timeout();
	endfunction

	// Request driver
	tftp_request_t offered;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_request(offered);
				requests_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_requests.size() > 0 &&
					(quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
					offered = pending_requests.pop_front();
					req_valid   <= 1'b1;
					mode        <= offered.mode;
					opcode      <= offered.opcode;
					block_num   <= offered.block_num;
					packet_len  <= offered.packet_len;
					peer_match  <= offered.peer_match;
					octet_ok    <= offered.octet_ok;
					open_result <= offered.open_result;
					read_failed <= offered.read_failed;
					chunk_len   <= offered.chunk_len;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	task automatic log_failure(string what, tftp_action_t want, tftp_action_t got);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display({"%s: expected act=%0d blk=%0d err=%0d len=%0d fin=%0b last=%0b,",
				" got act=%0d blk=%0d err=%0d len=%0d fin=%0b last=%0b"},
				what, want.action, want.out_block, want.err_code, want.out_len,
				want.finished, want.last, got.action, got.out_block, got.err_code,
				got.out_len, got.finished, got.last);
	endtask

	// Result monitor
	always @(posedge clk) begin
		tftp_action_t got;
		tftp_action_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				results_checked++;
				got = {action, out_block, err_code, out_len, finished, last};
				if (expected_actions.size() == 0) begin
					log_failure("unexpected result", '0, got);
				end else begin
					want = expected_actions.pop_front();
					if (got !== want)
						log_failure("mismatch", want, got);
				end
			end
		end
	end

	// Receiver stall: one long hold-off while the sender keeps offering
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (!hold_done && results_checked >= 300 &&
				pending_requests.size() > 50) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !quiet_window && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic wait_drained();
		while (pending_requests.size() != 0 || req_valid || expected_actions.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reconfigure(logic [9:0] bs, logic [3:0] ma);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= tts_pkg::REG_BLOCK_SIZE;
		cfg_data  <= bs;
		@(posedge clk);
		cfg_index <= tts_pkg::REG_MAX_ATTEMPTS;
		cfg_data  <= {6'd0, ma};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_block_size = bs;
		cfg_max_attempts = ma;
		settings_used++;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings
		queue_directed();
		queue_random(RANDOM_ITEMS);

		reconfigure(10'd8, 4'd1);
		queue_random(RANDOM_ITEMS);

		reconfigure(10'd512, 4'd15);
		queue_random(RANDOM_ITEMS);

		reconfigure(10'd37, 4'd3);
		queue_random(RANDOM_ITEMS);

		reconfigure(10'd8, 4'd15);
		queue_random(RANDOM_ITEMS);

		reconfigure(10'd300, 4'd2);
		queue_random(RANDOM_ITEMS);

		wait_drained();
		$display("Checked %0d results from %0d requests under %0d register settings.",
			results_checked, requests_accepted, settings_used);
		$display({"Read and write transfers with retries, strangers and a long output",
			" hold-off; %0d failure(s), %0d result(s) owed."},
			failures, expected_actions.size());
		if (failures == 0 && expected_actions.size() == 0) begin
			$display("** tftp_transfer_sequencer_core: PASSED **");
		end else begin
			$display("** tftp_transfer_sequencer_core: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		while (cycle_count < MAX_CYCLES)
			@(posedge clk);
		$display("Timed out after %0d cycles.", cycle_count);
		$display("** tftp_transfer_sequencer_core: FAILED **");
		$finish;
	end

endmodule
